// ===== src/swp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_pkg
// Shared types, constants and tables for the similarity-weighted predictor.
// ---------------------------------------------------------------------------
package swp_pkg;

    // default sizes of the sample and covariate stores
    localparam int MAX_SAMPLES_DEF    = 128;
    localparam int MAX_COVARIATES_DEF = 16;
    localparam int QUEUE_DEPTH        = 4;

    // fixed point constants
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // configuration register indexes
    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_THRESHOLD = 3'd1;
    localparam logic [2:0] REG_SCOUNT    = 3'd2;
    localparam logic [2:0] REG_CCOUNT    = 3'd3;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_COVAR  = 2'd2,
        OP_QUERY  = 2'd3
    } swp_op_t;

    // classified command passed from front to back
    typedef struct packed {
        swp_op_t     op;
        logic        wr;
        logic        predict;
        logic [6:0]  sidx;
        logic [3:0]  cidx;
        logic [1:0]  level;
        logic [31:0] va;
        logic [31:0] vb;
    } swp_cmd_t;

    // configuration register set
    typedef struct packed {
        logic        mode;
        logic [16:0] threshold;
        logic [7:0]  sample_count;
        logic [4:0]  covariate_count;
    } swp_cfg_t;

    // back end sequencer states
    typedef enum logic [4:0] {
        B_IDLE,
        B_SAMP,
        B_RD,
        B_PREP,
        B_MUL,
        B_CHK,
        B_DIV,
        B_SQ,
        B_EXP1,
        B_EXP2,
        B_ACC1,
        B_ACC2,
        B_ACC3,
        B_ACC4,
        B_FIN,
        B_UDIV,
        B_MDIV,
        B_OUT
    } swp_bstate_t;

    // 2^(-k/16) in Q1.16
    function automatic logic [16:0] pow2_frac(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== src/swp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_ram
// Generic single write port RAM with one registered read port.
// ---------------------------------------------------------------------------
module swp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/swp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_front
// Accepts input transactions, drops out of range writes, classifies them
// into commands for the queue, and holds the configuration registers.
// ---------------------------------------------------------------------------
module swp_front
    import swp_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int MAX_COVARIATES = MAX_COVARIATES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [6:0]  sample_index,
    input  wire logic [3:0]  covariate_index,
    input  wire logic [1:0]  level,
    input  wire logic [31:0] value_a,
    input  wire logic [31:0] value_b,
    input  wire logic        last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    input  wire logic        q_full,
    output logic             push,
    output swp_cmd_t         cmd,
    output swp_cfg_t         cfg
);

    swp_cfg_t cfg_reg;
    logic     s_ok;
    logic     c_ok;
    logic     accept;

    assign busy      = q_full;
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign accept    = start && !q_full;

    // range checks on the addressed entries
    assign s_ok = 32'(sample_index) < MAX_SAMPLES;
    assign c_ok = 32'(covariate_index) < MAX_COVARIATES;

    // classify the transaction
    always_comb
    begin
        cmd.op      = swp_op_t'(op);
        cmd.sidx    = sample_index;
        cmd.cidx    = covariate_index;
        cmd.level   = level;
        cmd.va      = value_a;
        cmd.vb      = value_b;
        cmd.predict = 1'b0;
        unique case (swp_op_t'(op))
            OP_SAMPLE: cmd.wr = s_ok && c_ok;
            OP_WEIGHT: cmd.wr = s_ok;
            OP_COVAR:  cmd.wr = c_ok;
            OP_QUERY:
            begin
                cmd.wr      = c_ok;
                cmd.predict = last;
            end
            default:   cmd.wr = 1'b0;
        endcase
    end

    // only commands with an effect enter the queue
    assign push = accept && (cmd.wr || cmd.predict);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode            <= 1'b0;
            cfg_reg.threshold       <= 17'd0;
            cfg_reg.sample_count    <= 8'd0;
            cfg_reg.covariate_count <= 5'd1;
        end
        else if (cfg_valid)
        begin
            priority case (cfg_index)
                REG_MODE:      cfg_reg.mode            <= cfg_data[0];
                REG_THRESHOLD: cfg_reg.threshold       <= cfg_data;
                REG_SCOUNT:    cfg_reg.sample_count    <= cfg_data[7:0];
                REG_CCOUNT:    cfg_reg.covariate_count <= cfg_data[4:0];
                default:       cfg_reg.mode            <= cfg_reg.mode;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== src/swp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_fifo
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module swp_fifo
    import swp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire swp_cmd_t din,
    input  wire logic     pop,
    output swp_cmd_t      head,
    output logic          full,
    output logic          empty
);

    swp_cmd_t        slots [DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign full  = cnt_reg == CW'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = slots[rp_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wp_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== src/swp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_back
// Executes queued commands: store writes, and on a prediction a sequencer
// that walks samples and covariates, then the final divisions.
// ---------------------------------------------------------------------------
module swp_back
    import swp_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int MAX_COVARIATES = MAX_COVARIATES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire swp_cfg_t     cfg,
    input  wire swp_cmd_t     head,
    input  wire logic         empty,
    output logic              pop,
    output logic              done,
    output logic signed [31:0] prediction,
    output logic       [16:0] uncertainty,
    output logic              no_data
);

    localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int KIW  = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;
    localparam int AW   = (MAX_SAMPLES * MAX_COVARIATES > 1) ?
                          $clog2(MAX_SAMPLES * MAX_COVARIATES) : 1;
    localparam int CJW  = $clog2(MAX_SAMPLES + 1);
    localparam int CKW  = $clog2(MAX_COVARIATES + 1);
    localparam int SW   = 34 + CJW;
    localparam int ACW  = 66 + CJW;
    localparam int NW   = ACW;
    localparam int DW   = SW;
    localparam int DCW  = $clog2(NW);

    swp_bstate_t state_reg, state_next;

    // per covariate stores
    logic [1:0]  lvl_q [MAX_COVARIATES];
    logic [31:0] gsd_q [MAX_COVARIATES];
    logic [31:0] qry_q [MAX_COVARIATES];

    // ram ports
    logic          cov_we;
    logic [AW-1:0] cov_waddr;
    logic [63:0]   cov_rdata;
    logic          smp_we;
    logic [SAW-1:0] smp_waddr;
    logic [63:0]   smp_rdata;

    // sequencer registers
    logic [CJW-1:0] j_reg;
    logic [CKW-1:0] k_reg;
    logic [AW-1:0]  addr_reg;
    logic [AW-1:0]  base_reg;
    logic [CJW-1:0] ns_reg;
    logic [CKW-1:0] nc_reg;
    logic [16:0]    floor_reg;
    logic           mode_reg;

    // similarity datapath registers
    logic           cat_reg;
    logic           eq_reg;
    logic [31:0]    amag_reg;
    logic [31:0]    smag_reg;
    logic [31:0]    gmag_reg;
    logic [63:0]    n_reg;
    logic [63:0]    d_reg;
    logic [63:0]    rem_reg;
    logic [18:0]    z_reg;
    logic [4:0]     step_reg;
    logic [20:0]    u_reg;
    logic [21:0]    t_reg;
    logic [16:0]    sim_reg;

    // accumulation registers
    logic signed [31:0]  max_w_reg;
    logic signed [49:0]  max_p_reg;
    logic signed [49:0]  p_reg;
    logic signed [33:0]  p16_reg;
    logic signed [31:0]  attr_reg;
    logic signed [31:0]  best_reg;
    logic                found_reg;
    logic signed [SW-1:0]  sum_reg;
    logic signed [65:0]    prod_reg;
    logic signed [ACW-1:0] acc_reg;

    // shared divider registers
    logic [NW-1:0]  dnum_reg;
    logic [DW-1:0]  dden_reg;
    logic [DW-1:0]  drem_reg;
    logic [DCW-1:0] dcnt_reg;
    logic           dneg_reg;

    // output registers
    logic signed [31:0] pred_reg;
    logic [16:0]        unc_reg;
    logic               nod_reg;

    // combinational helpers
    logic [KIW-1:0]     kix;
    logic               last_cov;
    logic               chk_done;
    logic [16:0]        chk_cs;
    logic [65:0]        ds_c;
    logic [64:0]        rx_c;
    logic               dge_c;
    logic [5:0]         ti_c;
    logic [3:0]         fk_c;
    logic [11:0]        fr_c;
    logic [16:0]        fa_c;
    logic [16:0]        fb_c;
    logic [23:0]        fd_c;
    logic [16:0]        fv_c;
    logic [16:0]        exp_cs;
    logic [16:0]        cs_c;
    logic               pass_c;
    logic signed [49:0] p_c;
    logic [49:0]        pn_c;
    logic signed [33:0] p16_c;
    logic [DW:0]        drx_c;
    logic               dq_c;
    logic [NW-1:0]      quo_c;
    logic               nodata_c;
    logic [ACW-1:0]     accm_c;
    logic [SW-1:0]      summ_c;
    logic [32:0]        qd_c;

    assign kix      = k_reg[KIW-1:0];
    assign last_cov = (k_reg + 1'b1) == nc_reg;

    // sample value and spread store
    swp_ram #(
        .WIDTH (64),
        .DEPTH (MAX_SAMPLES * MAX_COVARIATES)
    ) u_cov_ram (
        .clk   (clk),
        .we    (cov_we),
        .waddr (cov_waddr),
        .wdata ({head.vb, head.va}),
        .raddr (addr_reg),
        .rdata (cov_rdata)
    );

    // sample weight and attribute store
    swp_ram #(
        .WIDTH (64),
        .DEPTH (MAX_SAMPLES)
    ) u_smp_ram (
        .clk   (clk),
        .we    (smp_we),
        .waddr (smp_waddr),
        .wdata ({head.vb, head.va}),
        .raddr (j_reg[SAW-1:0]),
        .rdata (smp_rdata)
    );

    assign cov_waddr = AW'(32'(head.sidx) * MAX_COVARIATES + 32'(head.cidx));
    assign smp_waddr = SAW'(head.sidx);

    // categorical compare and gaussian pre-checks for zero numerator, zero spread and far samples
    always_comb
    begin
        chk_done = 1'b1;
        chk_cs   = 17'd0;
        priority if (cat_reg)
        begin
            chk_cs = eq_reg ? ONE_Q16 : 17'd0;
        end
        else if (n_reg == 64'd0)
        begin
            chk_cs = ONE_Q16;
        end
        else if (d_reg == 64'd0)
        begin
            chk_cs = 17'd0;
        end
        else if ({3'b000, n_reg} >= {d_reg, 3'b000})
        begin
            chk_cs = 17'd0;
        end
        else
        begin
            chk_done = 1'b0;
        end
    end

    // one quotient bit of z per cycle
    always_comb
    begin
        priority case (step_reg)
            5'd0:    ds_c = {d_reg, 2'b00};
            5'd1:    ds_c = {1'b0, d_reg, 1'b0};
            default: ds_c = {2'b00, d_reg};
        endcase
        rx_c  = (step_reg < 5'd3) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        dge_c = {1'b0, rx_c} >= ds_c;
    end

    // exp(-u) from table with linear interpolation
    always_comb
    begin
        ti_c   = t_reg[21:16];
        fk_c   = t_reg[15:12];
        fr_c   = t_reg[11:0];
        fa_c   = pow2_frac({1'b0, fk_c});
        fb_c   = pow2_frac({1'b0, fk_c} + 5'd1);
        fd_c   = 24'(fa_c - fb_c) * 24'(fr_c);
        fv_c   = fa_c - 17'(fd_c >> 12);
        exp_cs = (ti_c >= 6'd17) ? 17'd0 : (fv_c >> ti_c);
    end

    assign cs_c = (state_reg == B_EXP2) ? exp_cs : chk_cs;

    // sample score and truncated product
    always_comb
    begin
        pass_c = sim_reg >= floor_reg;
        p_c    = $signed({1'b0, sim_reg}) * $signed(smp_rdata[31:0]);
        pn_c   = 50'(-p_reg);
        p16_c  = p_reg[49] ? -$signed(pn_c[49:16]) : p_reg[49:16];
    end

    // shared restoring divider step
    always_comb
    begin
        drx_c = {drem_reg, dnum_reg[NW-1]};
        dq_c  = drx_c >= {1'b0, dden_reg};
        quo_c = {dnum_reg[NW-2:0], dq_c};
    end

    // end of walk
    always_comb
    begin
        nodata_c = mode_reg ? !found_reg : (sum_reg == '0 || max_w_reg == 32'sd0);
        accm_c   = acc_reg[ACW-1] ? ACW'(-acc_reg) : ACW'(acc_reg);
        summ_c   = sum_reg[SW-1] ? SW'(-sum_reg) : SW'(sum_reg);
        qd_c     = 33'(quo_c[31:0]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (!empty && head.predict)
                begin
                    state_next = B_SAMP;
                end
            B_SAMP:
                if (j_reg == ns_reg)
                begin
                    state_next = B_FIN;
                end
                else if (nc_reg == '0)
                begin
                    state_next = B_ACC1;
                end
                else
                begin
                    state_next = B_RD;
                end
            B_RD:   state_next = B_PREP;
            B_PREP: state_next = B_MUL;
            B_MUL:  state_next = B_CHK;
            B_CHK:
                if (!chk_done)
                begin
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = last_cov ? B_ACC1 : B_RD;
                end
            B_DIV:  state_next = (step_reg == 5'd18) ? B_SQ : B_DIV;
            B_SQ:   state_next = B_EXP1;
            B_EXP1: state_next = B_EXP2;
            B_EXP2: state_next = last_cov ? B_ACC1 : B_RD;
            B_ACC1: state_next = pass_c ? B_ACC2 : B_SAMP;
            B_ACC2: state_next = B_ACC3;
            B_ACC3: state_next = B_ACC4;
            B_ACC4: state_next = B_SAMP;
            B_FIN:  state_next = nodata_c ? B_OUT : B_UDIV;
            B_UDIV:
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    state_next = mode_reg ? B_OUT : B_MDIV;
                end
            B_MDIV:
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    state_next = B_OUT;
                end
            B_OUT:  state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop    = (state_reg == B_IDLE) && !empty;
        done   = state_reg == B_OUT;
        cov_we = pop && head.wr && (head.op == OP_SAMPLE);
        smp_we = pop && head.wr && (head.op == OP_WEIGHT);
    end

    assign prediction  = pred_reg;
    assign uncertainty = unc_reg;
    assign no_data     = nod_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // covariate info and query row
    always_ff @(posedge clk)
    begin
        if (pop && head.wr && head.op == OP_COVAR)
        begin
            lvl_q[KIW'(head.cidx)] <= head.level;
            gsd_q[KIW'(head.cidx)] <= head.va;
        end
        if (pop && head.wr && head.op == OP_QUERY)
        begin
            qry_q[KIW'(head.cidx)] <= head.va;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
                if (pop && head.predict)
                begin
                    j_reg     <= '0;
                    base_reg  <= '0;
                    ns_reg    <= (32'(cfg.sample_count) > MAX_SAMPLES) ?
                                 CJW'(MAX_SAMPLES) : CJW'(cfg.sample_count);
                    nc_reg    <= (32'(cfg.covariate_count) > MAX_COVARIATES) ?
                                 CKW'(MAX_COVARIATES) : CKW'(cfg.covariate_count);
                    floor_reg <= (cfg.threshold > ONE_Q16) ? 17'd0 :
                                 ONE_Q16 - cfg.threshold;
                    mode_reg  <= cfg.mode;
                    max_w_reg <= '0;
                    max_p_reg <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                    sum_reg   <= '0;
                    acc_reg   <= '0;
                end
            B_SAMP:
            begin
                sim_reg  <= ONE_Q16;
                k_reg    <= '0;
                addr_reg <= base_reg;
            end
            B_RD: ;
            // operand magnitudes
            B_PREP:
            begin
                cat_reg  <= lvl_q[kix] <= 2'd1;
                eq_reg   <= qry_q[kix] == cov_rdata[31:0];
                amag_reg <= 32'($signed({qry_q[kix][31], qry_q[kix]}) -
                                $signed({cov_rdata[31], cov_rdata[31:0]}) < 0 ?
                                {cov_rdata[31], cov_rdata[31:0]} -
                                {qry_q[kix][31], qry_q[kix]} :
                                {qry_q[kix][31], qry_q[kix]} -
                                {cov_rdata[31], cov_rdata[31:0]});
                smag_reg <= cov_rdata[63] ? 32'(-cov_rdata[63:32]) : cov_rdata[63:32];
                gmag_reg <= gsd_q[kix][31] ? 32'(-gsd_q[kix]) : gsd_q[kix];
            end
            // numerator and squared spread
            B_MUL:
            begin
                n_reg <= 64'(amag_reg) * 64'(smag_reg);
                d_reg <= 64'(gmag_reg) * 64'(gmag_reg);
            end
            B_CHK:
                if (chk_done)
                begin
                    if (cs_c < sim_reg)
                    begin
                        sim_reg <= cs_c;
                    end
                    k_reg    <= k_reg + 1'b1;
                    addr_reg <= addr_reg + 1'b1;
                end
                else
                begin
                    rem_reg  <= n_reg;
                    z_reg    <= '0;
                    step_reg <= '0;
                end
            B_DIV:
            begin
                rem_reg  <= dge_c ? 64'(rx_c - 65'(ds_c)) : 64'(rx_c);
                z_reg    <= {z_reg[17:0], dge_c};
                step_reg <= step_reg + 5'd1;
            end
            B_SQ:   u_reg <= 21'((38'(z_reg) * 38'(z_reg)) >> 17);
            B_EXP1: t_reg <= 22'((38'(u_reg) * 38'(LOG2E_Q16)) >> 16);
            B_EXP2:
            begin
                if (cs_c < sim_reg)
                begin
                    sim_reg <= cs_c;
                end
                k_reg    <= k_reg + 1'b1;
                addr_reg <= addr_reg + 1'b1;
            end
            // threshold, weight maximum and score
            B_ACC1:
            begin
                attr_reg <= smp_rdata[63:32];
                p_reg    <= p_c;
                if (pass_c)
                begin
                    if ($signed(smp_rdata[31:0]) > max_w_reg)
                    begin
                        max_w_reg <= smp_rdata[31:0];
                    end
                end
                else
                begin
                    j_reg    <= j_reg + 1'b1;
                    base_reg <= base_reg + AW'(MAX_COVARIATES);
                end
            end
            B_ACC2:
            begin
                if (p_reg > max_p_reg)
                begin
                    max_p_reg <= p_reg;
                    best_reg  <= attr_reg;
                    found_reg <= 1'b1;
                end
                p16_reg <= p16_c;
                sum_reg <= sum_reg + {{(SW - 34){p16_c[33]}}, p16_c};
            end
            B_ACC3: prod_reg <= p16_reg * attr_reg;
            B_ACC4:
            begin
                acc_reg  <= acc_reg + {{(ACW - 66){prod_reg[65]}}, prod_reg};
                j_reg    <= j_reg + 1'b1;
                base_reg <= base_reg + AW'(MAX_COVARIATES);
            end
            // no data or start of the uncertainty division
            B_FIN:
            begin
                pred_reg <= '0;
                unc_reg  <= ONE_Q16;
                nod_reg  <= nodata_c;
                dnum_reg <= NW'(max_p_reg[48:0]);
                dden_reg <= DW'(max_w_reg[30:0]);
                drem_reg <= '0;
                dcnt_reg <= '0;
            end
            B_UDIV:
            begin
                drem_reg <= dq_c ? DW'(drx_c - {1'b0, dden_reg}) : DW'(drx_c);
                dnum_reg <= quo_c;
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    unc_reg  <= ONE_Q16 - quo_c[16:0];
                    pred_reg <= best_reg;
                    dnum_reg <= accm_c;
                    dden_reg <= summ_c;
                    drem_reg <= '0;
                    dcnt_reg <= '0;
                    dneg_reg <= acc_reg[ACW-1] ^ sum_reg[SW-1];
                end
            end
            // weighted mean, truncated and saturated
            B_MDIV:
            begin
                drem_reg <= dq_c ? DW'(drx_c - {1'b0, dden_reg}) : DW'(drx_c);
                dnum_reg <= quo_c;
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(NW - 1))
                begin
                    if (dneg_reg)
                    begin
                        pred_reg <= (|quo_c[NW-1:32] || qd_c > 33'h080000000) ?
                                    32'sh80000000 : 32'(-quo_c[31:0]);
                    end
                    else
                    begin
                        pred_reg <= (|quo_c[NW-1:31]) ? 32'sh7FFFFFFF :
                                    $signed(quo_c[31:0]);
                    end
                end
            end
            B_OUT: ;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/similarity_weighted_prediction.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// similarity_weighted_prediction
// Similarity-weighted prediction of a property or class at one query point.
// ---------------------------------------------------------------------------
// Store and query transactions are done by the back end as it pops them; a four entry
// queue lets start be taken while the back end works.
// A prediction walks the samples and their covariates, each covariate settled
// by compare or with the bit-serial z division, then runs two divider passes;
// mode 1 skips the second divider pass, no data skips both.
// done is a single cycle strobe; the receiver cannot stall it. Reset (rst_n
// low, asynchronous) empties the queue and loads the register defaults.
module similarity_weighted_prediction
    import swp_pkg::*;
#(
    parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
    parameter int MAX_COVARIATES = MAX_COVARIATES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  op,
    input  wire logic [6:0]  sample_index,
    input  wire logic [3:0]  covariate_index,
    input  wire logic [1:0]  level,
    input  wire logic signed [31:0] value_a,
    input  wire logic signed [31:0] value_b,
    input  wire logic        last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data,
    output logic             done,
    output logic signed [31:0] prediction,
    output logic [16:0]      uncertainty,
    output logic             no_data
);

    swp_cmd_t push_cmd;
    swp_cmd_t head_cmd;
    swp_cfg_t cfg;
    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_empty;

    // intake and classification
    swp_front #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .MAX_COVARIATES (MAX_COVARIATES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .sample_index    (sample_index),
        .covariate_index (covariate_index),
        .level           (level),
        .value_a         (value_a),
        .value_b         (value_b),
        .last            (last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .push            (push),
        .cmd             (push_cmd),
        .cfg             (cfg)
    );

    // command queue
    swp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .head  (head_cmd),
        .full  (q_full),
        .empty (q_empty)
    );

    // execution
    swp_back #(
        .MAX_SAMPLES    (MAX_SAMPLES),
        .MAX_COVARIATES (MAX_COVARIATES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head        (head_cmd),
        .empty       (q_empty),
        .pop         (pop),
        .done        (done),
        .prediction  (prediction),
        .uncertainty (uncertainty),
        .no_data     (no_data)
    );

endmodule
`default_nettype wire

// ===== src/swp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swp_checker
// Port level checks on result transactions of the predictor.
// ---------------------------------------------------------------------------
module swp_checker
    import swp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [31:0] prediction,
    input wire logic [16:0] uncertainty,
    input wire logic        no_data
);

    // results never come in consecutive cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back to back result transactions");

    // a no data result carries the fixed values
    a_nodata_vals: assert property (@(posedge clk) disable iff (!rst_n)
        (done && no_data) |-> (prediction == 32'd0 && uncertainty == ONE_Q16))
        else $error("no data result with live payload");

    // uncertainty stays within one
    a_unc_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (uncertainty <= ONE_Q16))
        else $error("uncertainty above one");

    // queue not full and no result straight after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (!busy && !done))
        else $error("activity straight after reset");

endmodule

bind similarity_weighted_prediction swp_checker u_swp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .prediction  (prediction),
    .uncertainty (uncertainty),
    .no_data     (no_data)
);
`default_nettype wire
